// ===== rtl/encoder_average_pid_position_loop_top_assert.svh =====
// Assertion macros shared by the checker of the position loop.
// Depends on nothing; included by the checker file only.
`ifndef ENCODER_AVERAGE_PID_POSITION_LOOP_TOP_ASSERT_SVH
`define ENCODER_AVERAGE_PID_POSITION_LOOP_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define EAPL_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define EAPL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/eapl_pkg.sv =====
// Package of the encoder-averaged PID position loop: field widths, limits
// and configuration register indexes. Depends on nothing.
package eapl_pkg;

    localparam int ANGLE_W    = 16;
    localparam int POS_W      = 32;
    localparam int GAIN_W     = 16;
    localparam int EFFORT_W   = 12;
    localparam int PHASE_W    = 18;
    localparam int ERR_W      = 12;
    localparam int INTEG_W    = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int GAIN_SHIFT = 16;
    localparam int PID_W      = 37;

    localparam logic signed [PHASE_W-1:0] WRAP_HALF = 18'sd18000;
    localparam logic signed [PHASE_W-1:0] WRAP_FULL = 18'sd36000;
    localparam logic signed [ERR_W-1:0]   ERR_LIMIT = 12'sd2000;
    localparam logic signed [INTEG_W-1:0] INT_LIMIT = 17'sd50000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PROP_GAIN     = 3'd0,
        REG_INT_GAIN      = 3'd1,
        REG_DERIV_GAIN    = 3'd2,
        REG_EFFORT_LIMIT  = 3'd3,
        REG_PHASE_ADVANCE = 3'd4
    } cfg_reg_t;

endpackage

// ===== rtl/eapl_item_if.sv =====
// Input channel of the position loop: valid/ready plus one input item.
// Depends on eapl_pkg.
interface eapl_item_if;
    import eapl_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic [ANGLE_W-1:0]      encoder_angle;
    logic signed [POS_W-1:0] target;
    logic                    enable;

    modport source (output valid, op, encoder_angle, target, enable, input ready);
    modport sink (input valid, op, encoder_angle, target, enable, output ready);
endinterface

// ===== rtl/eapl_result_if.sv =====
// Output channel of the position loop: valid/ready plus one result item.
// Depends on eapl_pkg.
interface eapl_result_if;
    import eapl_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   filtered_position;
    logic                      drive_valid;
    logic signed [PHASE_W-1:0] phase_angle;
    logic [EFFORT_W-1:0]       effort;

    modport source (output valid, filtered_position, drive_valid, phase_angle, effort,
                    input ready);
    modport sink (input valid, filtered_position, drive_valid, phase_angle, effort,
                  output ready);
endinterface

// ===== rtl/encoder_average_pid_position_loop_top.sv =====
// Encoder-averaged PID position loop; depends on eapl_pkg, eapl_item_if, eapl_result_if.
// The result register loads from the input register once the output can advance.
// Throughput: one transaction per cycle unless the output stalls, set by the single
// compute stage between the input register and the result register, which also updates the loop state.
// Reset (rst_n low, asynchronous) clears the configuration, the averaging window,
// the position and the controller state; the block accepts items right after reset.
module encoder_average_pid_position_loop_top #(
    parameter int WINDOW_DEPTH  = 16,
    parameter int AVERAGE_SHIFT = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    eapl_item_if.sink                           item,
    eapl_result_if.source                       result,
    input  logic                                cfg_we,
    input  logic [eapl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [eapl_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import eapl_pkg::*;

    localparam int SUM_W = POS_W + $clog2(WINDOW_DEPTH);

    logic [GAIN_W-1:0]   prop_gain_reg;
    logic [GAIN_W-1:0]   int_gain_reg;
    logic [GAIN_W-1:0]   deriv_gain_reg;
    logic [EFFORT_W-1:0] effort_limit_reg;
    logic [ANGLE_W-1:0]  phase_advance_reg;

    logic                    s1_valid_reg;
    logic                    s1_op_reg;
    logic [ANGLE_W-1:0]      s1_angle_reg;
    logic signed [POS_W-1:0] s1_target_reg;
    logic                    s1_enable_reg;

    logic                      out_valid_reg;
    logic signed [POS_W-1:0]   out_filtered_reg;
    logic                      out_drive_reg;
    logic signed [PHASE_W-1:0] out_phase_reg;
    logic [EFFORT_W-1:0]       out_effort_reg;

    logic [ANGLE_W-1:0]      angle_reg;
    logic [POS_W-1:0]        unwrapped_reg;
    logic signed [POS_W-1:0] window_reg [WINDOW_DEPTH];
    logic signed [SUM_W-1:0] sum_reg;
    logic signed [POS_W-1:0] avg_reg;
    logic signed [INTEG_W-1:0] integral_reg;
    logic signed [ERR_W-1:0] prev_err_reg;

    logic advance;
    logic fire;
    logic enc_fire;
    logic ctl_fire;

    logic signed [PHASE_W-1:0] diff;
    logic signed [PHASE_W-1:0] delta;
    logic [POS_W-1:0]          unwrapped_next;
    logic signed [POS_W-1:0]   oldest;
    logic signed [SUM_W-1:0]   sum_next;
    logic signed [SUM_W-1:0]   sum_shifted;
    logic signed [POS_W-1:0]   avg_next;

    logic signed [POS_W:0]       err_raw;
    logic signed [ERR_W-1:0]     err_sat;
    logic signed [ERR_W-1:0]     err_next;
    logic signed [INTEG_W:0]     integ_raw;
    logic signed [INTEG_W-1:0]   integral_next;
    logic signed [ERR_W:0]       err_diff;
    logic signed [28:0]          p_term;
    logic signed [33:0]          i_term;
    logic signed [29:0]          d_term;
    logic signed [PID_W-1:0]     pid_sum;
    logic signed [PID_W-GAIN_SHIFT-1:0] u_shift;
    logic signed [EFFORT_W:0]    lim;
    logic signed [EFFORT_W:0]    neg_lim;
    logic signed [EFFORT_W:0]    u_clamp;
    logic [EFFORT_W:0]           u_mag;
    logic [PHASE_W-1:0]          ang_ext;
    logic [PHASE_W-1:0]          adv_ext;
    logic signed [PHASE_W-1:0]   phase_next;

    assign advance    = !out_valid_reg || result.ready;
    assign fire       = s1_valid_reg && advance;
    assign enc_fire   = fire && !s1_op_reg;
    assign ctl_fire   = fire && s1_op_reg;
    assign item.ready = !s1_valid_reg || advance;

    assign result.valid             = out_valid_reg;
    assign result.filtered_position = out_filtered_reg;
    assign result.drive_valid       = out_drive_reg;
    assign result.phase_angle       = out_phase_reg;
    assign result.effort            = out_effort_reg;

    always_comb
    begin
        diff = $signed({2'b00, s1_angle_reg}) - $signed({2'b00, angle_reg});
        if (diff < -WRAP_HALF)
        begin
            delta = diff + WRAP_FULL;
        end
        else if (diff > WRAP_HALF)
        begin
            delta = diff - WRAP_FULL;
        end
        else
        begin
            delta = diff;
        end
        unwrapped_next = unwrapped_reg + {{(POS_W-PHASE_W){delta[PHASE_W-1]}}, delta};
        oldest         = window_reg[WINDOW_DEPTH-1];
        sum_next       = sum_reg - SUM_W'(oldest) + SUM_W'($signed(unwrapped_next));
        sum_shifted    = sum_next >>> AVERAGE_SHIFT;
        avg_next       = sum_shifted[POS_W-1:0];
    end

    always_comb
    begin
        err_raw = $signed({s1_target_reg[POS_W-1], s1_target_reg})
                - $signed({avg_reg[POS_W-1], avg_reg});
        if (err_raw > ERR_LIMIT)
        begin
            err_sat = ERR_LIMIT;
        end
        else if (err_raw < -ERR_LIMIT)
        begin
            err_sat = -ERR_LIMIT;
        end
        else
        begin
            err_sat = err_raw[ERR_W-1:0];
        end
        err_next  = s1_enable_reg ? err_sat : '0;
        integ_raw = $signed({integral_reg[INTEG_W-1], integral_reg})
                  + (INTEG_W+1)'(err_next);
        if (!s1_enable_reg)
        begin
            integral_next = '0;
        end
        else if (integ_raw > INT_LIMIT)
        begin
            integral_next = INT_LIMIT;
        end
        else if (integ_raw < -INT_LIMIT)
        begin
            integral_next = -INT_LIMIT;
        end
        else
        begin
            integral_next = integ_raw[INTEG_W-1:0];
        end
        err_diff = (ERR_W+1)'(err_next) - (ERR_W+1)'(prev_err_reg);
        p_term   = $signed({1'b0, prop_gain_reg}) * err_next;
        i_term   = $signed({1'b0, int_gain_reg}) * integral_next;
        d_term   = $signed({1'b0, deriv_gain_reg}) * err_diff;
        pid_sum  = PID_W'(p_term) + PID_W'(i_term >>> 1) + PID_W'(d_term);
        u_shift  = s1_enable_reg ? pid_sum[PID_W-1:GAIN_SHIFT] : '0;
        lim      = $signed({1'b0, effort_limit_reg});
        neg_lim  = -lim;
        if (u_shift > lim)
        begin
            u_clamp = lim;
        end
        else if (u_shift < neg_lim)
        begin
            u_clamp = neg_lim;
        end
        else
        begin
            u_clamp = u_shift[EFFORT_W:0];
        end
        u_mag   = (u_clamp < 0) ? 13'(-u_clamp) : 13'(u_clamp);
        ang_ext = {2'b00, angle_reg};
        adv_ext = {2'b00, phase_advance_reg};
        if (u_clamp > 0)
        begin
            phase_next = $signed(-ang_ext - adv_ext);
        end
        else
        begin
            phase_next = $signed(adv_ext - ang_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prop_gain_reg     <= '0;
            int_gain_reg      <= '0;
            deriv_gain_reg    <= '0;
            effort_limit_reg  <= '0;
            phase_advance_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PROP_GAIN:     prop_gain_reg     <= cfg_data[GAIN_W-1:0];
                REG_INT_GAIN:      int_gain_reg      <= cfg_data[GAIN_W-1:0];
                REG_DERIV_GAIN:    deriv_gain_reg    <= cfg_data[GAIN_W-1:0];
                REG_EFFORT_LIMIT:  effort_limit_reg  <= cfg_data[EFFORT_W-1:0];
                REG_PHASE_ADVANCE: phase_advance_reg <= cfg_data[ANGLE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item.ready)
            begin
                s1_valid_reg <= item.valid;
            end
            if (advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item.valid && item.ready)
        begin
            s1_op_reg     <= item.op;
            s1_angle_reg  <= item.encoder_angle;
            s1_target_reg <= item.target;
            s1_enable_reg <= item.enable;
        end
        if (fire)
        begin
            out_drive_reg <= s1_op_reg;
            if (s1_op_reg)
            begin
                out_filtered_reg <= avg_reg;
                out_phase_reg    <= phase_next;
                out_effort_reg   <= u_mag[EFFORT_W-1:0];
            end
            else
            begin
                out_filtered_reg <= avg_next;
                out_phase_reg    <= '0;
                out_effort_reg   <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg     <= '0;
            unwrapped_reg <= '0;
            sum_reg       <= '0;
            avg_reg       <= '0;
            integral_reg  <= '0;
            prev_err_reg  <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                window_reg[i] <= '0;
            end
        end
        else
        begin
            if (enc_fire)
            begin
                angle_reg     <= s1_angle_reg;
                unwrapped_reg <= unwrapped_next;
                sum_reg       <= sum_next;
                avg_reg       <= avg_next;
                window_reg[0] <= $signed(unwrapped_next);
                for (int i = 1; i < WINDOW_DEPTH; i++)
                begin
                    window_reg[i] <= window_reg[i-1];
                end
            end
            if (ctl_fire)
            begin
                integral_reg <= integral_next;
                prev_err_reg <= err_next;
            end
        end
    end

endmodule

// ===== rtl/eapl_checker.sv =====
// Port-level checker of the position loop and its bind to the top level.
// Depends on eapl_pkg and encoder_average_pid_position_loop_top_assert.svh.
`include "encoder_average_pid_position_loop_top_assert.svh"

module eapl_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  item_valid,
    input logic                                  item_ready,
    input logic                                  result_valid,
    input logic                                  result_ready,
    input logic signed [eapl_pkg::POS_W-1:0]     filtered_position,
    input logic                                  drive_valid,
    input logic signed [eapl_pkg::PHASE_W-1:0]   phase_angle,
    input logic [eapl_pkg::EFFORT_W-1:0]         effort
);
    import eapl_pkg::*;

    // A stalled result keeps its whole payload.
    `EAPL_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && !result_ready,
        result_valid && $stable(filtered_position) && $stable(drive_valid)
        && $stable(phase_angle) && $stable(effort), "stalled result changed")

    // Encoder results carry no drive command.
    `EAPL_ASSERT_IMPLY(a_encoder_quiet, clk, rst_n, result_valid && !drive_valid,
        phase_angle == '0 && effort == '0, "encoder result carries drive data")

    // A result that appears in an empty output comes from an accepted input transaction held in the input register.
    `EAPL_ASSERT_IMPLY(a_result_origin, clk, rst_n, $rose(result_valid),
        $past(item_valid && item_ready, 2), "result without matching input")

    // A draining output never holds back the input side.
    `EAPL_ASSERT_IMPLY(a_flow_through, clk, rst_n, result_ready, item_ready,
        "input stalled while output drains")

endmodule

bind encoder_average_pid_position_loop_top eapl_checker u_eapl_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .item_valid        (item.valid),
    .item_ready        (item.ready),
    .result_valid      (result.valid),
    .result_ready      (result.ready),
    .filtered_position (result.filtered_position),
    .drive_valid       (result.drive_valid),
    .phase_angle       (result.phase_angle),
    .effort            (result.effort)
);

// ===== verif/testbench.sv =====
// Self-checking testbench of the encoder-averaged PID position loop. A scoreboard class
// predicts every result from the accepted transactions; plain tasks drive the block.
// Depends on eapl_pkg, eapl_item_if, eapl_result_if and encoder_average_pid_position_loop_top.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import eapl_pkg::*;

    localparam int AVG_DEPTH      = 16;
    localparam int AVG_SHIFT      = 4;
    localparam int HALF_TURN      = 18000;
    localparam int FULL_TURN      = 36000;
    localparam longint ERR_CLAMP  = 2000;
    localparam longint INT_CLAMP  = 50000;
    localparam int STALL_LIMIT    = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int SETTLE_CYCLES  = 4;
    localparam int SEGMENT_ITEMS  = 90;
    localparam int WINDUP_TICKS   = 30;

    localparam logic OP_ENCODER = 1'b0;
    localparam logic OP_TICK    = 1'b1;
    localparam logic [CFG_IDX_W-1:0] FIRST_SPARE_REG = 3'd5;
    localparam logic [CFG_IDX_W-1:0] LAST_SPARE_REG  = 3'd7;

    typedef struct packed {
        logic [POS_W-1:0]    position;
        logic                drive;
        logic [PHASE_W-1:0]  phase;
        logic [EFFORT_W-1:0] effort;
    } loop_result_t;

    class position_loop_scoreboard;
        longint prop_gain;
        longint int_gain;
        longint deriv_gain;
        longint effort_limit;
        longint phase_advance;
        int angle_now;
        int angle_last;
        logic [POS_W-1:0] unwrapped;
        logic signed [POS_W-1:0] window [AVG_DEPTH];
        longint window_total;
        int slot;
        logic signed [POS_W-1:0] averaged;
        longint integral;
        longint last_error;
        int errors;
        loop_result_t expected_results [$];

        function new();
            prop_gain = 0;
            int_gain = 0;
            deriv_gain = 0;
            effort_limit = 0;
            phase_advance = 0;
            angle_now = 0;
            angle_last = 0;
            unwrapped = '0;
            foreach (window[k])
            begin
                window[k] = '0;
            end
            window_total = 0;
            slot = 0;
            averaged = '0;
            integral = 0;
            last_error = 0;
            errors = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            case (index)
                REG_PROP_GAIN:     prop_gain = longint'(data);
                REG_INT_GAIN:      int_gain = longint'(data);
                REG_DERIV_GAIN:    deriv_gain = longint'(data);
                REG_EFFORT_LIMIT:  effort_limit = longint'(data[EFFORT_W-1:0]);
                REG_PHASE_ADVANCE: phase_advance = longint'(data);
                default: ;
            endcase
        endfunction

        function void predict_result(logic op, logic [ANGLE_W-1:0] angle,
                                     logic signed [POS_W-1:0] target, logic enable);
            loop_result_t r;
            int diff;
            int delta;
            logic [POS_W-1:0] next_pos;
            longint err;
            longint drive;
            longint phase;
            longint magnitude;
            if (op == OP_ENCODER)
            begin
                angle_now = int'(angle);
                diff = angle_now - angle_last;
                if (diff < -HALF_TURN)
                    delta = diff + FULL_TURN;
                else if (diff > HALF_TURN)
                    delta = diff - FULL_TURN;
                else
                    delta = diff;
                next_pos = unwrapped + delta;
                unwrapped = next_pos;
                window_total -= window[slot];
                window[slot] = unwrapped;
                window_total += window[slot];
                slot = (slot + 1) % AVG_DEPTH;
                averaged = 32'(window_total >>> AVG_SHIFT);
                angle_last = angle_now;
                r.position = averaged;
                r.drive = 1'b0;
                r.phase = '0;
                r.effort = '0;
            end
            else
            begin
                if (enable)
                begin
                    err = longint'(target) - longint'(averaged);
                    if (err > ERR_CLAMP)
                        err = ERR_CLAMP;
                    else if (err < -ERR_CLAMP)
                        err = -ERR_CLAMP;
                    integral = integral + err;
                    if (integral > INT_CLAMP)
                        integral = INT_CLAMP;
                    else if (integral < -INT_CLAMP)
                        integral = -INT_CLAMP;
                    drive = prop_gain * err + ((int_gain * integral) >>> 1)
                          + deriv_gain * (err - last_error);
                    drive = drive >>> GAIN_SHIFT;
                end
                else
                begin
                    err = 0;
                    drive = 0;
                    integral = 0;
                end
                if (drive > effort_limit)
                    drive = effort_limit;
                else if (drive < -effort_limit)
                    drive = -effort_limit;
                last_error = err;
                if (drive > 0)
                    phase = -longint'(angle_now) - phase_advance;
                else
                    phase = -longint'(angle_now) + phase_advance;
                magnitude = (drive < 0) ? -drive : drive;
                r.position = averaged;
                r.drive = 1'b1;
                r.phase = phase[PHASE_W-1:0];
                r.effort = magnitude[EFFORT_W-1:0];
            end
            expected_results.push_back(r);
        endfunction

        function void check_result(loop_result_t got);
            loop_result_t want;
            if (expected_results.size() == 0)
            begin
                $error("result transaction arrived with no expected result");
                errors++;
                return;
            end
            want = expected_results.pop_front();
            if (got.position !== want.position)
            begin
                $error("filtered_position: expected %0d, got %0d",
                       $signed(want.position), $signed(got.position));
                errors++;
            end
            if (got.drive !== want.drive)
            begin
                $error("drive_valid: expected %0d, got %0d", want.drive, got.drive);
                errors++;
            end
            if (got.phase !== want.phase)
            begin
                $error("phase_angle: expected %0d, got %0d",
                       $signed(want.phase), $signed(got.phase));
                errors++;
            end
            if (got.effort !== want.effort)
            begin
                $error("effort: expected %0d, got %0d", want.effort, got.effort);
                errors++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_request;
    int shaft;

    position_loop_scoreboard sb = new();

    eapl_item_if item_ch ();
    eapl_result_if result_ch ();

    encoder_average_pid_position_loop_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .item(item_ch),
        .result(result_ch),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Every accepted transaction on either channel is seen here at the rising edge.
    always @(posedge clk)
    begin
        loop_result_t observed;
        if (rst_n)
        begin
            if (item_ch.valid && item_ch.ready)
                sb.predict_result(item_ch.op, item_ch.encoder_angle, item_ch.target,
                                  item_ch.enable);
            if (result_ch.valid && result_ch.ready)
            begin
                observed.position = result_ch.filtered_position;
                observed.drive = result_ch.drive_valid;
                observed.phase = result_ch.phase_angle;
                observed.effort = result_ch.effort;
                sb.check_result(observed);
            end
        end
    end

    initial
    begin
        int hold_left;
        hold_left = 0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("simulation failed");
        $finish;
    end

    task automatic set_idling(int sender_pct, int receiver_pct);
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
    endtask

    task automatic send_item(logic op, logic [ANGLE_W-1:0] angle,
                             logic signed [POS_W-1:0] target, logic enable);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(negedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op <= op;
        item_ch.encoder_angle <= angle;
        item_ch.target <= target;
        item_ch.enable <= enable;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_encoder(logic [ANGLE_W-1:0] angle);
        send_item(OP_ENCODER, angle, POS_W'($urandom), 1'($urandom_range(1, 0)));
    endtask

    task automatic send_tick(logic signed [POS_W-1:0] target, logic enable);
        send_item(OP_TICK, ANGLE_W'($urandom), target, enable);
    endtask

    task automatic wait_drained();
        item_ch.valid <= 1'b0;
        while (sb.expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        sb.set_register(index, data);
        @(negedge clk);
    endtask

    task automatic program_registers(longint p_gain, longint i_gain, longint d_gain,
                                     longint limit, longint advance);
        wait_drained();
        write_register(REG_PROP_GAIN, CFG_DATA_W'(p_gain));
        write_register(REG_INT_GAIN, CFG_DATA_W'(i_gain));
        write_register(REG_DERIV_GAIN, CFG_DATA_W'(d_gain));
        write_register(REG_EFFORT_LIMIT, CFG_DATA_W'(limit));
        write_register(REG_PHASE_ADVANCE, CFG_DATA_W'(advance));
        write_register(CFG_IDX_W'($urandom_range(LAST_SPARE_REG, FIRST_SPARE_REG)),
                       CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_random();
        program_registers($urandom_range(65535), $urandom_range(65535), $urandom_range(65535),
                          $urandom_range(4095), $urandom_range(FULL_TURN));
    endtask

    task automatic run_traffic(int count);
        int k;
        int j;
        int pick;
        int step;
        int push;
        int windup_at;
        logic [ANGLE_W-1:0] angle;
        logic signed [POS_W-1:0] goal;
        push = 1;
        windup_at = $urandom_range(count - 1, 0);
        for (k = 0; k < count; k++)
        begin
            if (k == windup_at)
            begin
                for (j = 0; j < WINDUP_TICKS; j++)
                    send_tick(sb.averaged + push * int'($urandom_range(30000, 2500)), 1'b1);
                push = -push;
            end
            pick = $urandom_range(99);
            if (pick < 50)
            begin
                if ($urandom_range(19) == 0)
                begin
                    angle = ANGLE_W'($urandom_range(65535, 30000));
                end
                else
                begin
                    if ($urandom_range(4) == 0)
                        step = int'($urandom_range(FULL_TURN)) - HALF_TURN;
                    else
                        step = int'($urandom_range(1000)) - 500;
                    shaft = (shaft + step + FULL_TURN) % FULL_TURN;
                    angle = ANGLE_W'(shaft);
                end
                send_encoder(angle);
            end
            else
            begin
                if (pick < 80)
                    goal = sb.averaged + (int'($urandom_range(6000)) - 3000);
                else if (pick < 90)
                    goal = sb.averaged + push * int'($urandom_range(40000, 1000));
                else
                    goal = $urandom;
                if ($urandom_range(19) == 0)
                    push = -push;
                send_tick(goal, $urandom_range(9) != 0);
            end
        end
    endtask

    // Steps of just under half a turn make each sample that wraps cross the unwrap threshold.
    task automatic climb_half_turns();
        int k;
        for (k = 0; k < 3 * AVG_DEPTH; k++)
        begin
            shaft = (shaft + HALF_TURN - 1) % FULL_TURN;
            send_encoder(ANGLE_W'(shaft));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_ENCODER;
        item_ch.encoder_angle = '0;
        item_ch.target = '0;
        item_ch.enable = 1'b0;
        hold_request = 1'b0;
        shaft = 0;
        set_idling(10, 65);
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        send_tick(32'sh7FFF_FFFF, 1'b1);
        send_tick(-32'sd1, 1'b0);
        program_registers(65535, 65535, 65535, 4095, FULL_TURN);
        send_encoder(16'd35999);
        send_encoder(16'd17999);
        send_encoder(16'd35999);
        send_encoder(16'd0);
        send_encoder(16'hFFFF);
        send_encoder(16'd36000);
        send_encoder(16'd0);
        send_tick(32'sh8000_0000, 1'b1);
        send_tick(32'sh7FFF_FFFF, 1'b1);
        send_tick(sb.averaged, 1'b1);
        send_tick(sb.averaged, 1'b0);
        send_tick(sb.averaged + 1500, 1'b1);
        send_tick(sb.averaged - 1, 1'b1);
        send_encoder(16'd1000);
        send_tick(sb.averaged, 1'b1);
        program_registers(1, 0, 0, 0, 0);
        send_tick(32'sh7FFF_FFFF, 1'b1);
        send_tick(32'sh8000_0000, 1'b1);
        send_tick(32'sd0, 1'b1);

        program_random();
        run_traffic(SEGMENT_ITEMS);
        program_registers(65535, 65535, 65535, 4095, FULL_TURN);
        hold_request = 1'b1;
        run_traffic(SEGMENT_ITEMS);

        set_idling(65, 10);
        program_random();
        run_traffic(SEGMENT_ITEMS);
        program_registers(65535, 65535, 65535, $urandom_range(4095), 0);
        run_traffic(SEGMENT_ITEMS);

        set_idling(0, 0);
        program_random();
        run_traffic(SEGMENT_ITEMS);
        climb_half_turns();
        program_random();
        run_traffic(SEGMENT_ITEMS);

        wait_drained();
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
